/* rtl/core/spring_damper_force_defines.svh */
// Assertion macros used by the checker file (sdf_checker.sv).
`ifndef SPRING_DAMPER_FORCE_DEFINES_SVH
`define SPRING_DAMPER_FORCE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spring_damper_force: check failed");

// next-cycle implication, quiet during reset
`define SDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spring_damper_force: check failed");

// holds in the cycle after a reset cycle
`define SDF_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("spring_damper_force: reset check failed");

`endif

/* rtl/core/sdf_pkg.sv */
package sdf_pkg;

    localparam logic [31:0] STIFFNESS_RST   = 32'd65536;
    localparam logic [31:0] DAMPING_RST     = 32'd0;
    localparam logic [31:0] FORCE_SCALE_RST = 32'd65536;

    localparam int CFG_IDX_W = 2;
    localparam int SS_W      = 66;   // sum of three squared 32 bit magnitudes
    localparam int LEN_W     = 33;   // integer sqrt of SS_W bits
    localparam int NM_W      = 31;   // |n| <= 2^30
    localparam int RM_W      = 35;   // divider partial remainder

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS   = 2'd0,
        REG_DAMPING     = 2'd1,
        REG_FORCE_SCALE = 2'd2
    } t_reg_idx;

    // per-spring data that rides along the length and divide stages
    typedef struct packed {
        logic [2:0][31:0] dmag;
        logic [2:0]       dneg;
        logic [2:0][31:0] vmag;
        logic [2:0]       vneg;
        logic [30:0]      l0;
    } t_side;

endpackage

/* rtl/core/sdf_if.sv */
interface sdf_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] end_a_x;
    logic signed [31:0] end_a_y;
    logic signed [31:0] end_a_z;
    logic signed [31:0] end_b_x;
    logic signed [31:0] end_b_y;
    logic signed [31:0] end_b_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic        [30:0] rest_length;

    modport source (
        output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
               rel_vel_x, rel_vel_y, rel_vel_z, rest_length,
        input  ready
    );
    modport sink (
        input  valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
               rel_vel_x, rel_vel_y, rel_vel_z, rest_length,
        output ready
    );
endinterface

interface sdf_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic        [31:0] energy;
    logic               degenerate;

    modport source (
        output valid, force_x, force_y, force_z, energy, degenerate,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, energy, degenerate,
        output ready
    );
endinterface

interface sdf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sdf_pkg::CFG_IDX_W-1:0]      index;
    logic [31:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/spring_damper_force.sv */
// Spring force kernel for a mass-spring cloth.
// i_item takes one spring per request: both end positions, the relative
// velocity (A minus B) and the rest length, all Q16.16. o_res returns one
// request per spring: the saturated force on end A (the consumer subtracts
// it at end B), the elastic energy and a degenerate flag for zero length.
// i_cfg writes stiffness (0), damping (1) and force_scale (2); other
// indexes are dropped. Write it only while no spring is in flight.
// Throughput: one spring per cycle while o_res is not held. The pipeline has
// 3 front stages (difference, squares, sum), 33 square-root
// stages (one length bit each), 31 divider stages (one bit of the unit
// direction each, three lanes) and 10 back stages of multipliers.
// The whole pipeline advances together; when o_res holds a request that
// is not taken, every stage and i_item.ready hold until it is, so nothing
// is dropped or repeated. Bubbles travel as invalid stages.
// Reset clears all valid bits and loads the register defaults
// (stiffness 1.0, damping 0, force_scale 1.0).
module spring_damper_force (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdf_item_if.sink      i_item,
    sdf_res_if.source     o_res,
    sdf_cfg_if.sink       i_cfg
);

    localparam int SS_W  = sdf_pkg::SS_W;
    localparam int LEN_W = sdf_pkg::LEN_W;
    localparam int NM_W  = sdf_pkg::NM_W;

    logic        w_en;
    logic [31:0] r_stiff;
    logic [31:0] r_damp;
    logic [31:0] r_scale;

    // config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= sdf_pkg::STIFFNESS_RST;
            r_damp  <= sdf_pkg::DAMPING_RST;
            r_scale <= sdf_pkg::FORCE_SCALE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sdf_pkg::REG_STIFFNESS:   r_stiff <= i_cfg.data;
                sdf_pkg::REG_DAMPING:     r_damp  <= i_cfg.data;
                sdf_pkg::REG_FORCE_SCALE: r_scale <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- front
    logic                 r_out_vld;
    assign w_en         = !r_out_vld || o_res.ready;
    assign i_item.ready = w_en;

    logic [2:0][31:0]     w_a, w_b, w_v;
    logic [2:0][32:0]     w_d, w_dn;
    sdf_pkg::t_side       w_fa_side;

    assign w_a = {i_item.end_a_z, i_item.end_a_y, i_item.end_a_x};
    assign w_b = {i_item.end_b_z, i_item.end_b_y, i_item.end_b_x};
    assign w_v = {i_item.rel_vel_z, i_item.rel_vel_y, i_item.rel_vel_x};

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_d[l]  = {w_b[l][31], w_b[l]} - {w_a[l][31], w_a[l]};
            w_dn[l] = ~w_d[l] + 33'd1;
            w_fa_side.dneg[l] = w_d[l][32];
            w_fa_side.dmag[l] = w_d[l][32] ? w_dn[l][31:0] : w_d[l][31:0];
            w_fa_side.vneg[l] = w_v[l][31];
            w_fa_side.vmag[l] = w_v[l][31] ? (32'd0 - w_v[l]) : w_v[l];
        end
        w_fa_side.l0 = i_item.rest_length;
    end

    logic                 r_fa_vld, r_fb_vld, r_fc_vld;
    sdf_pkg::t_side       r_fa_side, r_fb_side, r_fc_side;
    logic [2:0][63:0]     r_fb_sq;
    logic [SS_W-1:0]      r_fc_ss;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fa_side <= w_fa_side;
            r_fb_side <= r_fa_side;
            for (int l = 0; l < 3; l++) begin
                r_fb_sq[l] <= r_fa_side.dmag[l] * r_fa_side.dmag[l];
            end
            r_fc_side <= r_fb_side;
            r_fc_ss   <= {2'b00, r_fb_sq[0]} + {2'b00, r_fb_sq[1]} + {2'b00, r_fb_sq[2]};
        end
    end

    // ---------------- length and direction
    logic                  u_vld;
    logic [LEN_W-1:0]      u_len;
    logic [2:0][NM_W-1:0]  u_nmag;
    sdf_pkg::t_side        u_side;

    sdf_len_div u_len_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_fc_vld),
        .i_ss    (r_fc_ss),
        .i_side  (r_fc_side),
        .o_vld   (u_vld),
        .o_len   (u_len),
        .o_nmag  (u_nmag),
        .o_side  (u_side)
    );

    // ---------------- back
    logic [8:0]            r_bk_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_vld  <= 1'b0;
            r_fb_vld  <= 1'b0;
            r_fc_vld  <= 1'b0;
            r_bk_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_fa_vld  <= i_item.valid;
            r_fb_vld  <= r_fa_vld;
            r_fc_vld  <= r_fb_vld;
            r_bk_vld  <= {r_bk_vld[7:0], u_vld};
            r_out_vld <= r_bk_vld[8];
        end
    end

    // P1
    logic signed [34:0]    r_p1_e;
    logic [2:0][62:0]      r_p1_tprod;
    logic [2:0]            r_p1_tneg;
    // direction rides to P7, degenerate flag to the output register
    logic [2:0][NM_W-1:0]  r_p1_nmag, r_p2_nmag, r_p3_nmag, r_p4_nmag, r_p5_nmag, r_p6_nmag;
    logic [2:0]            r_p1_nneg, r_p2_nneg, r_p3_nneg, r_p4_nneg, r_p5_nneg, r_p6_nneg;
    logic [8:0]            r_dg;
    // P2
    logic signed [34:0]    r_p2_vn;
    logic [32:0]           r_p2_emag;
    logic                  r_p2_eneg;
    // P3
    logic [65:0]           r_p3_esq_raw;
    logic [64:0]           r_p3_hk_raw;
    logic [32:0]           r_p3_vnmag;
    logic                  r_p3_vnneg, r_p3_eneg;
    // P4
    logic [49:0]           r_p4_esq;
    logic [48:0]           r_p4_hk;
    logic [64:0]           r_p4_dm_raw;
    logic                  r_p4_vnneg, r_p4_eneg;
    // P5
    logic signed [51:0]    r_p5_s;
    logic [63:0]           r_p5_en_lo;
    logic [49:0]           r_p5_en_hi;
    // P6
    logic [50:0]           r_p6_smag;
    logic                  r_p6_sneg;
    logic [31:0]           r_p6_energy, r_p7_energy, r_p8_energy, r_p9_energy;
    // P7..P9
    logic [2:0][62:0]      r_p7_flo;
    logic [2:0][49:0]      r_p7_fhi;
    logic [2:0]            r_p7_fneg, r_p8_fneg, r_p9_fneg;
    logic [2:0][50:0]      r_p8_fmag;
    logic [2:0][63:0]      r_p9_glo;
    logic [2:0][50:0]      r_p9_ghi;
    // output
    logic [2:0][31:0]      r_out_f;
    logic [31:0]           r_out_energy;
    logic                  r_out_degen;

    // combinational pieces between stages
    logic [2:0][32:0]      w_term_mag;
    logic [2:0][34:0]      w_term;
    logic [34:0]           w_e_neg;
    logic [34:0]           w_vn_neg;
    logic [48:0]           w_dm;
    logic signed [51:0]    w_hk_s, w_dm_s;
    logic [51:0]           w_s_neg;
    logic [81:0]           w_en_full;
    logic [2:0][81:0]      w_f_full;
    logic [2:0][82:0]      w_g_full;
    logic [2:0][66:0]      w_gmag;
    logic [2:0][31:0]      w_force;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_term_mag[l] = r_p1_tprod[l][62:30];
            w_term[l]     = r_p1_tneg[l] ? (35'd0 - {2'b00, w_term_mag[l]})
                                         : {2'b00, w_term_mag[l]};
        end
        w_e_neg  = 35'd0 - r_p1_e;
        w_vn_neg = 35'd0 - r_p2_vn;

        w_dm   = r_p4_dm_raw[64:16];
        w_hk_s = r_p4_eneg  ? -$signed({3'b000, r_p4_hk}) : $signed({3'b000, r_p4_hk});
        w_dm_s = r_p4_vnneg ? -$signed({3'b000, w_dm})    : $signed({3'b000, w_dm});
        w_s_neg = 52'd0 - r_p5_s;

        w_en_full = {r_p5_en_hi, 32'd0} + {18'd0, r_p5_en_lo};

        for (int l = 0; l < 3; l++) begin
            w_f_full[l] = {r_p7_fhi[l], 32'd0} + {19'd0, r_p7_flo[l]};
            w_g_full[l] = {r_p9_ghi[l], 32'd0} + {19'd0, r_p9_glo[l]};
            w_gmag[l]   = w_g_full[l][82:16];
            if (!r_p9_fneg[l]) begin
                w_force[l] = (|w_gmag[l][66:31]) ? 32'h7FFF_FFFF : w_gmag[l][31:0];
            end else if ((|w_gmag[l][66:32]) || (w_gmag[l][31] && (|w_gmag[l][30:0]))) begin
                w_force[l] = 32'h8000_0000;
            end else begin
                w_force[l] = 32'd0 - w_gmag[l][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // P1: length error, velocity projection products
            r_p1_e <= $signed({2'b00, u_len}) - $signed({4'b0000, u_side.l0});
            for (int l = 0; l < 3; l++) begin
                r_p1_tprod[l] <= u_nmag[l] * u_side.vmag[l];
            end
            r_p1_tneg <= u_side.dneg ^ u_side.vneg;
            r_p1_nmag <= u_nmag;
            r_p1_nneg <= u_side.dneg;
            r_dg      <= {r_dg[7:0], (u_len == '0)};

            // P2: n . v, |e|
            r_p2_vn   <= $signed(w_term[0]) + $signed(w_term[1]) + $signed(w_term[2]);
            r_p2_eneg <= r_p1_e[34];
            r_p2_emag <= r_p1_e[34] ? w_e_neg[32:0] : r_p1_e[32:0];
            r_p2_nmag <= r_p1_nmag;
            r_p2_nneg <= r_p1_nneg;

            // P3: e^2, k*|e|, |vn|
            r_p3_esq_raw <= r_p2_emag * r_p2_emag;
            r_p3_hk_raw  <= r_stiff * r_p2_emag;
            r_p3_vnneg   <= r_p2_vn[34];
            r_p3_vnmag   <= r_p2_vn[34] ? w_vn_neg[32:0] : r_p2_vn[32:0];
            r_p3_eneg    <= r_p2_eneg;
            r_p3_nmag    <= r_p2_nmag;
            r_p3_nneg    <= r_p2_nneg;

            // P4: damping product
            r_p4_esq    <= r_p3_esq_raw[65:16];
            r_p4_hk     <= r_p3_hk_raw[64:16];
            r_p4_dm_raw <= r_damp * r_p3_vnmag;
            r_p4_vnneg  <= r_p3_vnneg;
            r_p4_eneg   <= r_p3_eneg;
            r_p4_nmag   <= r_p3_nmag;
            r_p4_nneg   <= r_p3_nneg;

            // P5: spring scalar, energy partial products
            r_p5_s     <= w_hk_s - w_dm_s;
            r_p5_en_lo <= r_stiff * r_p4_esq[31:0];
            r_p5_en_hi <= r_stiff * r_p4_esq[49:32];
            r_p5_nmag  <= r_p4_nmag;
            r_p5_nneg  <= r_p4_nneg;

            // P6: |s|, energy = k*esq / 2^17 clamped
            r_p6_sneg   <= r_p5_s[51];
            r_p6_smag   <= r_p5_s[51] ? w_s_neg[50:0] : r_p5_s[50:0];
            r_p6_energy <= (|w_en_full[81:49]) ? 32'hFFFF_FFFF : w_en_full[48:17];
            r_p6_nmag   <= r_p5_nmag;
            r_p6_nneg   <= r_p5_nneg;

            // P7: s * n, split on s
            for (int l = 0; l < 3; l++) begin
                r_p7_flo[l] <= r_p6_smag[31:0]  * r_p6_nmag[l];
                r_p7_fhi[l] <= r_p6_smag[50:32] * r_p6_nmag[l];
            end
            r_p7_fneg   <= {3{r_p6_sneg}} ^ r_p6_nneg;
            r_p7_energy <= r_p6_energy;

            // P8
            for (int l = 0; l < 3; l++) begin
                r_p8_fmag[l] <= w_f_full[l][80:30];
            end
            r_p8_fneg   <= r_p7_fneg;
            r_p8_energy <= r_p7_energy;

            // P9: f * force_scale, split on f
            for (int l = 0; l < 3; l++) begin
                r_p9_glo[l] <= r_p8_fmag[l][31:0]  * r_scale;
                r_p9_ghi[l] <= r_p8_fmag[l][50:32] * r_scale;
            end
            r_p9_fneg   <= r_p8_fneg;
            r_p9_energy <= r_p8_energy;

            // output register
            r_out_f      <= r_dg[8] ? '0 : w_force;
            r_out_degen  <= r_dg[8];
            r_out_energy <= r_p9_energy;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.force_x    = r_out_f[0];
    assign o_res.force_y    = r_out_f[1];
    assign o_res.force_z    = r_out_f[2];
    assign o_res.energy     = r_out_energy;
    assign o_res.degenerate = r_out_degen;

endmodule

/* rtl/core/sdf_len_div.sv */
module sdf_len_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic [sdf_pkg::SS_W-1:0]           i_ss,
    input  sdf_pkg::t_side                     i_side,
    output logic                               o_vld,
    output logic [sdf_pkg::LEN_W-1:0]          o_len,
    output logic [2:0][sdf_pkg::NM_W-1:0]      o_nmag,
    output sdf_pkg::t_side                     o_side
);

    localparam int SS_W  = sdf_pkg::SS_W;
    localparam int LEN_W = sdf_pkg::LEN_W;
    localparam int NM_W  = sdf_pkg::NM_W;
    localparam int RM_W  = sdf_pkg::RM_W;
    localparam int SQ    = LEN_W;   // one result bit per stage
    localparam int DV    = NM_W;    // one quotient bit per stage

    logic                    r_sq_vld  [SQ];
    logic [SS_W-1:0]         r_sq_rem  [SQ];
    logic [LEN_W-1:0]        r_sq_len  [SQ];
    sdf_pkg::t_side          r_sq_side [SQ];

    logic                    r_dv_vld  [DV];
    logic [2:0][RM_W-1:0]    r_dv_rem  [DV];
    logic [2:0][NM_W-1:0]    r_dv_q    [DV];
    logic [LEN_W-1:0]        r_dv_len  [DV];
    sdf_pkg::t_side          r_dv_side [DV];

    // digit-by-digit square root, rem = ss - len^2
    for (genvar s = 0; s < SQ; s++) begin : g_sq
        localparam int B = SQ - 1 - s;
        logic                 w_vld;
        logic [SS_W-1:0]      w_rem;
        logic [LEN_W-1:0]     w_len;
        sdf_pkg::t_side       w_side;
        logic [SS_W:0]        w_trial;
        logic                 w_take;

        if (s == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_ss;
            assign w_len  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_sq_vld[s-1];
            assign w_rem  = r_sq_rem[s-1];
            assign w_len  = r_sq_len[s-1];
            assign w_side = r_sq_side[s-1];
        end

        // (len + 2^B)^2 - len^2
        assign w_trial = ({{(SS_W+1-LEN_W){1'b0}}, w_len} << (B + 1))
                       + ({{SS_W{1'b0}}, 1'b1} << (2 * B));
        assign w_take  = (w_trial <= {1'b0, w_rem});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[s]  <= w_take ? (w_rem - w_trial[SS_W-1:0]) : w_rem;
                r_sq_len[s]  <= w_take ? (w_len | ({{(LEN_W-1){1'b0}}, 1'b1} << B)) : w_len;
                r_sq_side[s] <= w_side;
            end
        end
    end

    // restoring divide |d| * 2^30 / len, three lanes
    for (genvar t = 0; t < DV; t++) begin : g_dv
        localparam int Q = DV - 1 - t;
        logic                 w_vld;
        logic [LEN_W-1:0]     w_len;
        sdf_pkg::t_side       w_side;
        logic [2:0][RM_W-1:0] w_rem_prev;
        logic [2:0][NM_W-1:0] w_q_prev;
        logic [2:0][RM_W-1:0] w_sh;
        logic [2:0]           w_ge;
        logic [2:0][RM_W-1:0] n_rem;
        logic [2:0][NM_W-1:0] n_q;

        if (t == 0) begin : g_first
            assign w_vld      = r_sq_vld[SQ-1];
            assign w_len      = r_sq_len[SQ-1];
            assign w_side     = r_sq_side[SQ-1];
            assign w_rem_prev = '0;
            assign w_q_prev   = '0;
        end else begin : g_next
            assign w_vld      = r_dv_vld[t-1];
            assign w_len      = r_dv_len[t-1];
            assign w_side     = r_dv_side[t-1];
            assign w_rem_prev = r_dv_rem[t-1];
            assign w_q_prev   = r_dv_q[t-1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                // first step takes |d| itself: |d| <= len, so the top bit is 2^30
                if (t == 0) begin
                    w_sh[l] = {{(RM_W-32){1'b0}}, w_side.dmag[l]};
                end else begin
                    w_sh[l] = {w_rem_prev[l][RM_W-2:0], 1'b0};
                end
                w_ge[l]  = (w_sh[l] >= {{(RM_W-LEN_W){1'b0}}, w_len});
                n_rem[l] = w_ge[l] ? (w_sh[l] - {{(RM_W-LEN_W){1'b0}}, w_len}) : w_sh[l];
                n_q[l]   = w_q_prev[l] | ({{(NM_W-1){1'b0}}, w_ge[l]} << Q);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[t] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[t] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[t]  <= n_rem;
                r_dv_q[t]    <= n_q;
                r_dv_len[t]  <= w_len;
                r_dv_side[t] <= w_side;
            end
        end
    end

    assign o_vld  = r_dv_vld[DV-1];
    assign o_len  = r_dv_len[DV-1];
    assign o_nmag = r_dv_q[DV-1];
    assign o_side = r_dv_side[DV-1];

endmodule

/* rtl/core/sdf_checker.sv */
`include "spring_damper_force_defines.svh"

module sdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_force_x,
    input logic [31:0] i_force_y,
    input logic [31:0] i_force_z,
    input logic [31:0] i_energy,
    input logic        i_degenerate
);

    logic w_force_zero;
    logic w_out_stall;

    assign w_force_zero = (i_force_x == 32'd0) && (i_force_y == 32'd0) && (i_force_z == 32'd0);
    assign w_out_stall  = i_out_valid && !i_out_ready;

    // a zero-length spring carries no force
    `SDF_ASSERT_IMP(a_degen_zero, i_out_valid && i_degenerate, w_force_zero)

    // a held result stalls the input side too
    `SDF_ASSERT_IMP(a_stall_back, w_out_stall, !i_in_ready)

    `SDF_ASSERT_NXT(a_out_hold, w_out_stall, i_out_valid && $stable(i_force_x) && $stable(i_energy))

    `SDF_ASSERT_RST(a_rst_empty, !i_out_valid)

endmodule

bind spring_damper_force sdf_checker u_sdf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_force_x    (o_res.force_x),
    .i_force_y    (o_res.force_y),
    .i_force_z    (o_res.force_z),
    .i_energy     (o_res.energy),
    .i_degenerate (o_res.degenerate)
);

/* verif/tb_sdf_if.sv */
`timescale 1ns / 100ps

// Stub file: the channel interfaces come from the RTL (sdf_if.sv).
// This package holds the expected-result record shared by the bench.
package tb_sdf_pkg;
    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic        [31:0] energy;
        logic               degenerate;
    } t_force_res;
endpackage

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam longint SAT = 64'sh3FFFFFFFFFFFFFFF;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sdf_item_if item_if();
    sdf_res_if  res_if();
    sdf_cfg_if  cfg_if();

    spring_damper_force i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] v [3];
        logic        [30:0] l0;
    } t_spring;

    typedef struct {
        t_spring                 sp;
        bit                      known;
        tb_sdf_pkg::t_force_res  res;
    } t_row;

    logic [31:0]            k_reg, damp_reg, scale_reg;
    tb_sdf_pkg::t_force_res force_q[$];
    int                     errors = 0;
    int                     cycles = 0;
    bit                     calm = 0;

    task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SAT) return SAT;
        if (s < -SAT) return -SAT;
        return s;
    endfunction

    // sign-magnitude product, truncated shift, symmetric saturation
    function automatic longint mshift(longint a, longint b, int sh);
        logic [63:0] ma, mb;
        logic [127:0] p;
        longint r;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = {64'd0, ma} * {64'd0, mb};
        p = p >> sh;
        if (p > SAT) r = SAT;
        else r = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic tb_sdf_pkg::t_force_res spring_force(t_spring sp);
        tb_sdf_pkg::t_force_res r;
        longint d[3], n[3], len, e, esq, en, hooke, vn, dmp, s, f, g;
        logic [65:0] ss;
        logic [69:0] c;
        ss = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(sp.b[i]) - longint'(sp.a[i]);
            ss += 66'(d[i] < 0 ? -d[i] : d[i]) * 66'(d[i] < 0 ? -d[i] : d[i]);
        end
        len = 0;
        for (int bt = 33; bt >= 0; bt--) begin
            c = 70'(len) | (70'd1 << bt);
            if (c * c <= {4'd0, ss}) len = longint'(c);
        end
        e = len - longint'({1'b0, sp.l0});
        esq = mshift(e, e, 16);
        en = mshift(longint'(k_reg), esq, 17);
        r.energy = en > 64'shFFFFFFFF ? 32'hFFFFFFFF : en[31:0];
        if (len == 0) begin
            r.fx = 0; r.fy = 0; r.fz = 0; r.degenerate = 1;
            return r;
        end
        vn = 0;
        for (int i = 0; i < 3; i++) begin
            n[i] = (d[i] * (64'sd1 << 30)) / len;
            vn = sat_sum(vn, mshift(n[i], longint'(sp.v[i]), 30));
        end
        hooke = mshift(longint'(k_reg), e, 16);
        dmp = mshift(longint'(damp_reg), vn, 16);
        s = sat_sum(hooke, -dmp);
        for (int i = 0; i < 3; i++) begin
            f = mshift(s, n[i], 30);
            g = mshift(f, longint'(scale_reg), 16);
            if (g > 64'sh7FFFFFFF) g = 64'sh7FFFFFFF;
            if (g < -64'sh80000000) g = -64'sh80000000;
            if (i == 0) r.fx = g[31:0];
            else if (i == 1) r.fy = g[31:0];
            else r.fz = g[31:0];
        end
        r.degenerate = 0;
        return r;
    endfunction

    initial begin
        item_if.valid = 0; cfg_if.valid = 0; res_if.ready = 0;
        cfg_if.index = sdf_pkg::REG_STIFFNESS; cfg_if.data = 0;
        item_if.end_a_x = 0; item_if.end_a_y = 0; item_if.end_a_z = 0;
        item_if.end_b_x = 0; item_if.end_b_y = 0; item_if.end_b_z = 0;
        item_if.rel_vel_x = 0; item_if.rel_vel_y = 0; item_if.rel_vel_z = 0;
        item_if.rest_length = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: random stall, compare against oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (force_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                tb_sdf_pkg::t_force_res w;
                w = force_q.pop_front();
                if (res_if.force_x !== w.fx) report("force_x", res_if.force_x, w.fx);
                if (res_if.force_y !== w.fy) report("force_y", res_if.force_y, w.fy);
                if (res_if.force_z !== w.fz) report("force_z", res_if.force_z, w.fz);
                if (res_if.energy !== w.energy) report("energy", res_if.energy, w.energy);
                if (res_if.degenerate !== w.degenerate)
                    report("degenerate", res_if.degenerate, w.degenerate);
            end
        end
        res_if.ready <= calm || ($urandom_range(99) >= 35);
    end

    task automatic cfg_write(sdf_pkg::t_reg_idx idx, logic [31:0] val);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            sdf_pkg::REG_STIFFNESS:   k_reg = val;
            sdf_pkg::REG_DAMPING:     damp_reg = val;
            sdf_pkg::REG_FORCE_SCALE: scale_reg = val;
            default: ;
        endcase
    endtask

    task automatic send_spring(t_spring sp, bit known, tb_sdf_pkg::t_force_res want);
        while (!calm && $urandom_range(99) < 35) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.end_a_x <= sp.a[0]; item_if.end_a_y <= sp.a[1]; item_if.end_a_z <= sp.a[2];
        item_if.end_b_x <= sp.b[0]; item_if.end_b_y <= sp.b[1]; item_if.end_b_z <= sp.b[2];
        item_if.rel_vel_x <= sp.v[0]; item_if.rel_vel_y <= sp.v[1];
        item_if.rel_vel_z <= sp.v[2];
        item_if.rest_length <= sp.l0;
        item_if.valid <= 1'b1;
        do @(posedge i_clk); while (!item_if.ready);
        force_q = {force_q, (known ? want : spring_force(sp))};
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(2000000)) - 1000000;
            2: return $signed($urandom_range(400)) - 200;
            default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    function automatic t_spring rand_spring();
        t_spring sp;
        int mode;
        mode = $urandom_range(9) < 6 ? 1 : $urandom_range(3);
        for (int i = 0; i < 3; i++) begin
            sp.a[i] = rand_coord(mode);
            sp.b[i] = ($urandom_range(15) == 0) ? sp.a[i] : rand_coord(mode);
            sp.v[i] = rand_coord($urandom_range(3));
        end
        sp.l0 = $urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(300000));
        return sp;
    endfunction

    t_row rows[$];

    initial begin
        t_spring sp;
        t_row r;
        logic [31:0] settings[4][3];
        k_reg = sdf_pkg::STIFFNESS_RST;
        damp_reg = sdf_pkg::DAMPING_RST;
        scale_reg = sdf_pkg::FORCE_SCALE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero spring after reset, energy zero
        foreach (sp.a[i]) begin sp.a[i] = 0; sp.b[i] = 0; sp.v[i] = 0; end
        sp.l0 = 0;
        r.sp = sp; r.known = 1; r.res = '{0, 0, 0, 0, 1}; rows = {rows, r};
        // unit spring along x at rest: no force
        sp.b[0] = 32'h10000; sp.l0 = 31'h10000;
        r.sp = sp; r.known = 1; r.res = '{0, 0, 0, 0, 0}; rows = {rows, r};
        // unit spring stretched by one unit: force +1 on A along x, energy 0.5
        sp.b[0] = 32'h20000;
        r.sp = sp; r.known = 1; r.res = '{32'h10000, 0, 0, 32'h8000, 0}; rows = {rows, r};
        r.known = 0;
        // degenerate with rest length: energy still computed
        sp.b[0] = 0; sp.l0 = 31'h30000; r.sp = sp; rows = {rows, r};
        sp.l0 = 31'h7FFFFFFF; r.sp = sp; rows = {rows, r};
        // extreme corners
        foreach (sp.a[i]) begin
            sp.a[i] = 32'h80000000; sp.b[i] = 32'h7FFFFFFF; sp.v[i] = 32'h7FFFFFFF;
        end
        sp.l0 = 0; r.sp = sp; rows = {rows, r};
        foreach (sp.a[i]) begin
            sp.a[i] = 32'h7FFFFFFF; sp.b[i] = 32'h80000000; sp.v[i] = 32'h80000000;
        end
        sp.l0 = 31'h7FFFFFFF; r.sp = sp; rows = {rows, r};
        sp.a = '{32'h0, 32'h7FFFFFFF, 32'h0}; sp.b = '{32'h1, 32'h0, 32'h80000000};
        sp.v = '{32'hFFFFFFFF, 32'h1, 32'h0}; sp.l0 = 31'h1; r.sp = sp; rows = {rows, r};
        foreach (rows[j]) send_spring(rows[j].sp, rows[j].known, rows[j].res);
        drain();

        settings[0] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        settings[1] = '{32'h0, 32'h0, 32'h0};
        settings[2] = '{32'h28000, 32'h8000, 32'h10000};
        settings[3] = '{32'h3, 32'h1234, 32'hFFFFFFFF};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) begin
                cfg_write(sdf_pkg::REG_STIFFNESS, settings[ph][0]);
                cfg_write(sdf_pkg::REG_DAMPING, settings[ph][1]);
                cfg_write(sdf_pkg::REG_FORCE_SCALE, settings[ph][2]);
            end else begin
                cfg_write(sdf_pkg::REG_STIFFNESS, $urandom());
                cfg_write(sdf_pkg::REG_DAMPING, $urandom_range(300000));
                cfg_write(sdf_pkg::REG_FORCE_SCALE, $urandom_range(200000));
                cfg_write(sdf_pkg::t_reg_idx'(2'd3), $urandom()); // dropped index
            end
            if (ph == 0) foreach (rows[j]) send_spring(rows[j].sp, 0, rows[j].res);
            calm = (ph == 2);
            for (int n = 0; n < 90; n++) send_spring(rand_spring(), 0, r.res);
            calm = 0;
            drain();
        end

        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
